/* hw/rtl/mtg_pkg.sv */
// Package: constants of the Mersenne Twister generator.
package mtg_pkg;
  localparam int unsigned STATE_WORDS_DEF = 624;
  localparam int unsigned TAP_OFFSET_DEF  = 397;

  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [31:0] MATRIX_CONST = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] RESET_SEED   = 32'd5489;

  typedef logic [31:0] word_t;
endpackage

/* hw/rtl/mtg_cell.sv */
// One state word of the shift chain; loads its upstream neighbor on shift.
module mtg_cell (
  input  logic           clk,
  input  logic           shift,
  input  mtg_pkg::word_t d,
  output mtg_pkg::word_t q
);
  import mtg_pkg::*;

  word_t word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;
endmodule

/* hw/rtl/mtg_seeder.sv */
// Seeding recurrence: next init word from the current one and its index.
module mtg_seeder #(
  parameter int unsigned IDX_W = 10
) (
  input  mtg_pkg::word_t   s,
  input  logic [IDX_W-1:0] idx,
  output mtg_pkg::word_t   s_next
);
  import mtg_pkg::*;

  word_t mixed;

  assign mixed  = s ^ (s >> 30);
  assign s_next = INIT_MULT * mixed + (32'(idx) + 32'd1);
endmodule

/* hw/rtl/mtg_twist_temper.sv */
// Per-word twist of the oldest chain words and tempering of the new word.
module mtg_twist_temper (
  input  mtg_pkg::word_t w_cur,
  input  mtg_pkg::word_t w_nxt,
  input  mtg_pkg::word_t w_tap,
  output mtg_pkg::word_t new_word,
  output mtg_pkg::word_t tempered
);
  import mtg_pkg::*;

  word_t x;
  word_t t1;
  word_t t2;
  word_t t3;

  always_comb begin
    x        = (w_cur & UPPER_MASK) | (w_nxt & LOWER_MASK);
    new_word = w_tap ^ (x >> 1) ^ (w_nxt[0] ? MATRIX_CONST : '0);
    t1       = new_word ^ (new_word >> 11);
    t2       = t1 ^ ((t1 << 7) & TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end
endmodule

/* hw/rtl/mersenne_twister_generator.sv */
// Top level: MT19937 generator built as a ring of word cells with per-word twist.
//
// The state lives in a chain of STATE_WORDS (624) word cells. For each ordinary
// item the twist unit combines the two oldest words and the tap word, the
// chain shifts by one and the tempered new word goes into the output
// register, so items stream at one per cycle while the output is taken.
// After reset, and after an item with restart set, the seeding unit fills the
// chain one word per cycle while no item is accepted; a restart item's result
// is made in ST_PEND once the output slot is free. Seed writes are taken
// at any time and act at the next restart.
module mersenne_twister_generator #(
  parameter int unsigned STATE_WORDS = mtg_pkg::STATE_WORDS_DEF,
  parameter int unsigned TAP_OFFSET  = mtg_pkg::TAP_OFFSET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  mtg_pkg::word_t cfg_seed,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_restart,
  output logic           out_valid,
  input  logic           out_ready,
  output mtg_pkg::word_t out_value
);
  import mtg_pkg::*;

  localparam int unsigned IDX_W = $clog2(STATE_WORDS);

  typedef enum logic [1:0] {
    ST_SEED,
    ST_PEND,
    ST_RUN
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;
  word_t            s_r;
  word_t            seed_r;
  logic             pend_r;
  logic             out_valid_r;
  word_t            out_value_r;

  word_t            chain_q [STATE_WORDS];
  word_t            feed;
  word_t            s_next;
  word_t            new_word;
  word_t            tempered;
  logic             slot_free;
  logic             accept;
  logic             step;
  logic             shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= RESET_SEED;
    end else if (cfg_valid) begin
      seed_r <= cfg_seed;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_RUN) && slot_free;
  assign accept    = in_valid && in_ready;
  assign step      = ((state_r == ST_PEND) && slot_free) || (accept && !in_restart);
  assign shift     = (state_r == ST_SEED) || step;
  assign feed      = (state_r == ST_SEED) ? s_r : new_word;

  mtg_seeder #(
    .IDX_W(IDX_W)
  ) u_seeder (
    .s     (s_r),
    .idx   (cnt_r),
    .s_next(s_next)
  );

  mtg_twist_temper u_twist (
    .w_cur   (chain_q[0]),
    .w_nxt   (chain_q[1]),
    .w_tap   (chain_q[TAP_OFFSET]),
    .new_word(new_word),
    .tempered(tempered)
  );

  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_chain
    word_t d_k;
    if (k == STATE_WORDS - 1) begin : g_last
      assign d_k = feed;
    end else begin : g_mid
      assign d_k = chain_q[k+1];
    end
    mtg_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .d    (d_k),
      .q    (chain_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED;
      cnt_r       <= '0;
      s_r         <= RESET_SEED;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
        out_value_r <= tempered;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_SEED: begin
          s_r <= s_next;
          if (cnt_r == IDX_W'(STATE_WORDS - 1)) begin
            cnt_r   <= '0;
            state_r <= pend_r ? ST_PEND : ST_RUN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_PEND: begin
          if (slot_free) begin
            pend_r  <= 1'b0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept && in_restart) begin
            s_r     <= seed_r;
            cnt_r   <= '0;
            pend_r  <= 1'b1;
            state_r <= ST_SEED;
          end
        end
        default: begin
          state_r <= ST_SEED;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_no_accept_while_seeding: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !in_ready)
    else $error("item accepted while the chain is not ready");

  a_restart_starts_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_restart) |=> (state_r == ST_SEED) && (cnt_r == '0) && pend_r)
    else $error("restart item did not start seeding");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_restart) |=> out_valid_r)
    else $error("ordinary item gave no result");

  a_pend_only_after_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PEND) |-> pend_r)
    else $error("pending result without a restart item");
endmodule

/* test/testbench.sv */
// Testbench for the MT19937 generator: directed table, then random phases checked by a predictor.
module testbench;
  import mtg_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int SETTLE_CYCLES = 700;

  typedef struct packed {
    logic  is_cfg;
    word_t seed_val;
    logic  restart;
    logic  known;
    word_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd3499211612},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd581869302},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd3890346734},
    '{1'b0, 32'd0, 1'b1, 1'b1, 32'd3499211612},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd581869302},
    '{1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'd0},
    // seed write alone leaves the running sequence alone
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd3890346734},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd3586334585},
    '{1'b0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{1'b1, RESET_SEED, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 32'd0, 1'b1, 1'b1, 32'd3499211612},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd581869302},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd3890346734},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd3586334585},
    '{1'b0, 32'd0, 1'b0, 1'b1, 32'd545404204}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  word_t cfg_seed = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  in_restart = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t out_value;

  mersenne_twister_generator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_seed(cfg_seed),
    .in_valid(in_valid), .in_ready(in_ready), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value)
  );

  always #10 clk = ~clk;

  // predictor state
  word_t mt_words [STATE_WORDS_DEF];
  int    mt_pos;
  word_t mt_seed;

  word_t pending_values [$];
  int    mismatches = 0;
  int    items_sent = 0;
  bit    steady = 1'b0;
  int    ready_hold = 0;

  function automatic void reseed_words(word_t s);
    word_t w;
    w = s;
    for (int i = 0; i < STATE_WORDS_DEF; i++) begin
      mt_words[i] = w;
      w = INIT_MULT * (w ^ (w >> 30)) + word_t'(i + 1);
    end
    mt_pos = STATE_WORDS_DEF;
  endfunction

  function automatic void twist_words();
    word_t nxt, tap, x;
    for (int i = 0; i < STATE_WORDS_DEF; i++) begin
      nxt = mt_words[(i + 1) % STATE_WORDS_DEF];
      tap = mt_words[(i + TAP_OFFSET_DEF) % STATE_WORDS_DEF];
      x = (mt_words[i] & UPPER_MASK) | (nxt & LOWER_MASK);
      mt_words[i] = tap ^ (x >> 1) ^ (nxt[0] ? MATRIX_CONST : 32'd0);
    end
    mt_pos = 0;
  endfunction

  function automatic word_t temper_word(word_t r);
    word_t t;
    t = r ^ (r >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic word_t next_value(bit restart);
    word_t r;
    if (restart) reseed_words(mt_seed);
    if (mt_pos >= STATE_WORDS_DEF) twist_words();
    r = mt_words[mt_pos];
    mt_pos++;
    return temper_word(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_values.size() == 0) begin
        if (mismatches < 10) $display("unexpected item: value %h", out_value);
        mismatches++;
      end else begin
        want = pending_values.pop_front();
        if (out_value !== want) begin
          if (mismatches < 10)
            $display("mismatch: value expected %h got %h", want, out_value);
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(bit restart, bit known, word_t want, bit last);
    word_t predicted;
    int gap;
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_value(restart);
    pending_values.push_back(known ? want : predicted);
    items_sent++;
    gap = steady ? 0 : pick_gap();
    if (last && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_seed(word_t value);
    while (pending_values.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_seed <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mt_seed = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    bit restart;
    mt_seed = RESET_SEED;
    reseed_words(mt_seed);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (PLAN[k].is_cfg) begin
        write_seed(PLAN[k].seed_val);
      end else begin
        send_item(PLAN[k].restart, PLAN[k].known, PLAN[k].want,
                  k == PLAN_ROWS - 1 || PLAN[k + 1].is_cfg);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 1 || items_sent < PLAN_ROWS)
        write_seed($urandom());
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 300);
      if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
      for (int k = 0; k < n; k++) begin
        restart = (k == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 199) == 0);
        send_item(restart, 1'b0, '0, k == n - 1);
      end
    end
    steady = 1'b0;

    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end
endmodule
